[rtl/core/mcc_pkg.sv]
// Shared types, constants and reset values for the color compositor.
package mcc_pkg;

    localparam int NUM_CHANNELS  = 4;
    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 16;
    localparam int LEVEL_BITS    = 16;
    localparam int SETUP_BITS    = 57;
    localparam int CFG_IDX_BITS  = 3;
    localparam int FRAC_W        = FRACTION_BITS + 1;
    localparam int QUOT_W        = FRACTION_BITS;
    localparam int DIFF_W        = LEVEL_BITS + 1;
    localparam int PROD_W        = FRAC_W + 8;
    localparam int SUM_W         = PROD_W + 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_SINGLE = CFG_IDX_BITS'(NUM_CHANNELS);

    typedef struct packed {
        logic [15:0] sample_ch3;
        logic [15:0] sample_ch2;
        logic [15:0] sample_ch1;
        logic [15:0] sample_ch0;
    } in_word_t;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
    } out_word_t;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0] index;
        logic [63:0]             data;
    } cfg_word_t;

    typedef struct packed {
        logic        enable;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [15:0] high;
        logic [15:0] low;
    } setup_t;

    // One divide stage's carried state for a channel.
    typedef struct packed {
        logic              zero;   // force fraction 0
        logic              one;    // force fraction 1.0
        logic [DIFF_W-1:0] rem;
        logic [DIFF_W-1:0] den;
        logic [QUOT_W-1:0] quot;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } div_t;

    function automatic setup_t setup_reset(input int k);
        setup_t s;
        s.enable = 1'b1;
        s.low    = 16'h0000;
        s.high   = 16'hFFFF;
        unique case (k % 6)
            0: begin s.red = 8'd255; s.green = 8'd255; s.blue = 8'd255; end
            1: begin s.red = 8'd0;   s.green = 8'd255; s.blue = 8'd0;   end
            2: begin s.red = 8'd255; s.green = 8'd0;   s.blue = 8'd255; end
            3: begin s.red = 8'd255; s.green = 8'd170; s.blue = 8'd0;   end
            4: begin s.red = 8'd0;   s.green = 8'd255; s.blue = 8'd255; end
            default: begin s.red = 8'd255; s.green = 8'd80; s.blue = 8'd80; end
        endcase
        return s;
    endfunction

endpackage

[rtl/core/mcc_window.sv]
// Window setup stage: differences, clamps and divider seed per channel.
module mcc_window (
    input  mcc_pkg::setup_t               setup,
    input  logic                          single,
    input  logic [mcc_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [mcc_pkg::SAMPLE_BITS-1:0] sample0,
    output mcc_pkg::div_t                 seed
);
    import mcc_pkg::*;

    logic [SAMPLE_BITS-1:0] s;
    logic signed [SAMPLE_BITS+1:0] num;
    logic signed [SAMPLE_BITS+1:0] den;
    logic signed [SAMPLE_BITS+1:0] num_a;
    logic signed [SAMPLE_BITS+1:0] den_a;

    always_comb
    begin
        s   = single ? sample0 : sample;
        num = $signed({2'b00, s}) - $signed({2'b00, setup.low});
        den = $signed({2'b00, setup.high}) - $signed({2'b00, setup.low});
        num_a = den[SAMPLE_BITS+1] ? -num : num;
        den_a = den[SAMPLE_BITS+1] ? -den : den;
        seed.zero  = !setup.enable || (den == '0) || num_a[SAMPLE_BITS+1] || (num_a == '0);
        seed.one   = !seed.zero && (num_a >= den_a);
        seed.rem   = num_a[DIFF_W-1:0];
        seed.den   = den_a[DIFF_W-1:0];
        seed.quot  = '0;
        seed.red   = setup.red;
        seed.green = setup.green;
        seed.blue  = setup.blue;
    end

endmodule

[rtl/core/mcc_divstep.sv]
// Restoring divider steps: two quotient bits per pipeline stage.
module mcc_divstep (
    input  mcc_pkg::div_t d,
    output mcc_pkg::div_t q
);
    import mcc_pkg::*;

    logic [DIFF_W:0] t;
    div_t w;

    always_comb
    begin
        w = d;
        for (int i = 0; i < 2; i++)
        begin
            t = {w.rem, 1'b0};
            if (t >= {1'b0, w.den})
            begin
                w.rem  = DIFF_W'(t - {1'b0, w.den});
                w.quot = {w.quot[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                w.rem  = t[DIFF_W-1:0];
                w.quot = {w.quot[QUOT_W-2:0], 1'b0};
            end
        end
        q = w;
    end

endmodule

[rtl/core/multichannel_color_composite.sv]
// Top level of the multichannel false-color compositor.
// Takes one word of four 16-bit samples per clock and returns one RGB word.
// Each enabled channel windows its sample by its low/high levels into a
// Q1.16 fraction (exact truncated division), scales its 8-bit color, and the
// channels are summed per color, shifted down 16 bits and saturated at 255.
// Rate: one word per clock unless stalled. Stages: one window stage, eight
// divider stages of two quotient bits each, one multiply stage, one
// sum/saturate stage. The whole pipe advances when the output register is
// empty or being taken, so a stall holds every stage in place.
// Configuration may be written only while the pipe is empty.
module multichannel_color_composite (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mcc_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mcc_pkg::out_word_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  mcc_pkg::cfg_word_t  cfg_data
);
    import mcc_pkg::*;

    localparam int DIV_STAGES = QUOT_W / 2;
    localparam int NST = DIV_STAGES + 3;

    setup_t setup_reg [NUM_CHANNELS];
    logic   single_reg;

    logic advance;
    logic [NST-1:0] valid_reg;

    div_t pipe_reg [DIV_STAGES+1][NUM_CHANNELS];
    div_t seed     [NUM_CHANNELS];
    div_t step_out [DIV_STAGES][NUM_CHANNELS];

    logic [PROD_W-1:0] prod_reg [NUM_CHANNELS][3];
    out_word_t out_reg;

    logic [SAMPLE_BITS-1:0] samples [NUM_CHANNELS];

    assign samples[0] = in_data.sample_ch0;
    assign samples[1] = in_data.sample_ch1;
    assign samples[2] = in_data.sample_ch2;
    assign samples[3] = in_data.sample_ch3;

    // Advance when the output register is free or being taken.
    assign advance   = !valid_reg[NST-1] || out_ready;
    assign in_ready  = advance;
    assign cfg_ready = 1'b1;
    assign out_valid = valid_reg[NST-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CHANNELS; k++)
                setup_reg[k] <= setup_reset(k);
            single_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int k = 0; k < NUM_CHANNELS; k++)
                if (cfg_data.index == CFG_IDX_BITS'(k))
                    setup_reg[k] <= setup_t'(cfg_data.data[SETUP_BITS-1:0]);
            if (cfg_data.index == REG_SINGLE)
                single_reg <= cfg_data.data[0];
        end
    end

    genvar g, s;
    generate
        for (g = 0; g < NUM_CHANNELS; g++)
        begin : g_chan
            mcc_window u_win (
                .setup   (setup_reg[g]),
                .single  (single_reg),
                .sample  (samples[g]),
                .sample0 (samples[0]),
                .seed    (seed[g])
            );
            for (s = 0; s < DIV_STAGES; s++)
            begin : g_div
                mcc_divstep u_step (
                    .d (pipe_reg[s][g]),
                    .q (step_out[s][g])
                );
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[NST-2:0], in_valid};
    end

    // Payload: hold on stall, advance otherwise.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < NUM_CHANNELS; k++)
            begin
                pipe_reg[0][k] <= seed[k];
                for (int i = 0; i < DIV_STAGES; i++)
                    pipe_reg[i+1][k] <= step_out[i][k];
            end
        end
    end

    logic [FRAC_W-1:0] frac [NUM_CHANNELS];
    always_comb
    begin
        for (int k = 0; k < NUM_CHANNELS; k++)
        begin
            if (pipe_reg[DIV_STAGES][k].zero)
                frac[k] = '0;
            else if (pipe_reg[DIV_STAGES][k].one)
                frac[k] = FRAC_W'(1) << FRACTION_BITS;
            else
                frac[k] = {1'b0, pipe_reg[DIV_STAGES][k].quot};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < NUM_CHANNELS; k++)
            begin
                prod_reg[k][0] <= PROD_W'(frac[k]) * PROD_W'(pipe_reg[DIV_STAGES][k].red);
                prod_reg[k][1] <= PROD_W'(frac[k]) * PROD_W'(pipe_reg[DIV_STAGES][k].green);
                prod_reg[k][2] <= PROD_W'(frac[k]) * PROD_W'(pipe_reg[DIV_STAGES][k].blue);
            end
        end
    end

    logic [SUM_W-1:0] sum [3];
    logic [7:0]       sat [3];
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sum[j] = '0;
            for (int k = 0; k < NUM_CHANNELS; k++)
                sum[j] = sum[j] + SUM_W'(prod_reg[k][j]);
            sat[j] = (sum[j][SUM_W-1:FRACTION_BITS] > (SUM_W-FRACTION_BITS)'(255))
                     ? 8'hFF : sum[j][FRACTION_BITS+7:FRACTION_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.red_out   <= sat[0];
            out_reg.green_out <= sat[1];
            out_reg.blue_out  <= sat[2];
        end
    end

    // A stalled output word must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed under stall");

    // Accepted word enters the pipe.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted word lost at entry");

    // Stall freezes the valid chain.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_reg))
        else $error("pipe moved during stall");

endmodule
